>>> hdl/bba_pkg.sv
// shared types and codes for the buddy block allocator
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

	// request beat
	typedef struct packed {
		logic        action;
		logic [13:0] request_size;
		logic [15:0] block_address;
	} req_beat_t;

	// response beat
	typedef struct packed {
		logic [15:0] granted_address;
		logic [1:0]  status;
	} rsp_beat_t;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OOM   = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_UNUSED = 2'd0,
		KIND_SPLIT  = 2'd1,
		KIND_WHOLE  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_PSCAN,
		S_SRD,
		S_SCHK,
		S_SPL,
		S_MRD,
		S_MWR,
		S_BUD,
		S_BRD,
		S_BCHK,
		S_FIN
	} state_t;

	localparam logic [3:0] PAGES_ALLOWED_RST = 4'd8;

endpackage
`default_nettype wire

>>> hdl/bba_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

>>> hdl/bba_row_search.sv
// lowest free node of one tree level within one bitmap row
`timescale 1ns / 1ps
`default_nettype none
module bba_row_search #(
	parameter int SIZE_LEVELS = 10,
	parameter int ROW_LOG2    = 6
) (
	input  wire logic [(1<<ROW_LOG2)-1:0]            row_data,
	input  wire logic [SIZE_LEVELS-ROW_LOG2:0]       row_idx,
	input  wire logic [$clog2(SIZE_LEVELS+1)-1:0]    level,
	output logic                                     hit,
	output logic [ROW_LOG2-1:0]                      hit_bit
);

	localparam int W = 1 << ROW_LOG2;

	always_comb begin
		int n;
		int lo;
		lo      = 1 << (SIZE_LEVELS - int'(level));
		hit     = 1'b0;
		hit_bit = '0;
		// scan downward so the lowest matching bit wins
		for (int b = W - 1; b >= 0; b--) begin
			n = (int'(row_idx) << ROW_LOG2) + b;
			if (row_data[b] && n >= lo && n < 2 * lo) begin
				hit     = 1'b1;
				hit_bit = ROW_LOG2'(b);
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/buddy_block_allocator.sv
// buddy block allocator top: sequencer, page table and bitmap ram
// one beat in flight; stall is high from accept until the response is loaded
// allocate: decode, a read and check per bitmap row, a step per unsplit page or level, a page
//   scan, a split, read and write per split level, the load; free: decode, a buddy step, read
//   and check per merged level and for the last buddy, the mark's read and write, the load;
//   rejected or ignored: decode, load; async reset clears page table, row valid bits, control
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator
	import bba_pkg::*;
#(
	parameter int NUM_PAGES      = 8,
	parameter int SIZE_LEVELS    = 10,
	parameter int MIN_BLOCK_LOG2 = 3
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_beat_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_beat_t      rsp,
	input  wire logic      cfg_we,
	input  wire logic [3:0] cfg_wdata
);

	// tree geometry: node n of a page lives at bit n of the page's bitmap
	localparam int PAGE_LOG2 = MIN_BLOCK_LOG2 + SIZE_LEVELS;
	localparam int NB        = SIZE_LEVELS + 1;
	localparam int ROW_LOG2  = (SIZE_LEVELS < 6) ? SIZE_LEVELS : 6;
	localparam int W         = 1 << ROW_LOG2;
	localparam int RB        = NB - ROW_LOG2;
	localparam int ROWS      = 1 << RB;
	localparam int PW        = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int PAGES_P2  = 1 << PW;
	localparam int PCW       = $clog2(NUM_PAGES + 1);
	localparam int AW        = PW + RB;
	localparam int DEPTH     = 1 << AW;
	localparam int LW        = $clog2(SIZE_LEVELS + 1);

	state_t state_q, state_d;

	req_beat_t            req_q;
	rsp_beat_t            rsp_q;
	logic                 rsp_valid_q;
	logic [3:0]           pages_allowed_q;
	kind_t                page_kind_q [PAGES_P2];
	logic [DEPTH-1:0]     row_valid_q;
	logic [PCW-1:0]       pg_q;
	logic [LW-1:0]        cur_q;
	logic [LW-1:0]        lvl_q;
	logic [RB-1:0]        row_q;
	logic [ROW_LOG2-1:0]  bit_q;
	logic [PAGE_LOG2-1:0] off_q;
	logic                 whole_q;
	logic                 grant_q;
	status_t              status_q;

	// bitmap ram port
	logic [AW-1:0] ram_addr;
	logic          ram_we;
	logic [W-1:0]  ram_wdata;
	logic [W-1:0]  ram_rdata;
	logic [W-1:0]  row_val;

	logic                hit;
	logic [ROW_LOG2-1:0] hit_bit;

	// --- geometry helpers ---
	function automatic logic [RB-1:0] first_row(input logic [LW-1:0] lv);
		logic [31:0] t;
		t = (32'(1) << (SIZE_LEVELS - int'(lv))) >> ROW_LOG2;
		first_row = t[RB-1:0];
	endfunction

	function automatic logic [RB-1:0] last_row(input logic [LW-1:0] lv);
		logic [31:0] t;
		t = ((32'(2) << (SIZE_LEVELS - int'(lv))) - 32'(1)) >> ROW_LOG2;
		last_row = t[RB-1:0];
	endfunction

	function automatic logic [NB-1:0] node_of(input logic [LW-1:0] lv,
			input logic [PAGE_LOG2-1:0] o);
		logic [31:0] t;
		t = (32'(1) << (SIZE_LEVELS - int'(lv))) | (32'(o) >> (MIN_BLOCK_LOG2 + int'(lv)));
		node_of = t[NB-1:0];
	endfunction

	function automatic logic [PAGE_LOG2-1:0] blk(input logic [LW-1:0] lv);
		logic [31:0] t;
		t = 32'(1) << (MIN_BLOCK_LOG2 + int'(lv));
		blk = t[PAGE_LOG2-1:0];
	endfunction

	// --- decode of the held request ---
	logic [LW-1:0]        dec_lvl;
	logic                 dec_bad;
	logic                 dec_whole;
	logic [15:0]          fa_page;
	logic                 fa_page_ok;
	logic [PAGE_LOG2-1:0] fa_off;
	kind_t                fa_kind;

	always_comb begin
		logic [31:0] t;
		dec_lvl = LW'(SIZE_LEVELS);
		for (int l = SIZE_LEVELS - 1; l >= 0; l--) begin
			if ((32'(1) << (MIN_BLOCK_LOG2 + l)) >= 32'(req_q.request_size)) begin
				dec_lvl = LW'(l);
			end
		end
		dec_bad    = (req_q.request_size == '0) ||
		             (32'(req_q.request_size) > (32'(1) << PAGE_LOG2));
		dec_whole  = (dec_lvl == LW'(SIZE_LEVELS));
		fa_page    = req_q.block_address >> PAGE_LOG2;
		fa_page_ok = (32'(fa_page) < 32'(NUM_PAGES));
		// page offset with the bits below the block size cleared
		t = 32'(req_q.block_address) & ((32'(1) << PAGE_LOG2) - 32'(1));
		t = t & ~((32'(1) << (MIN_BLOCK_LOG2 + int'(dec_lvl))) - 32'(1));
		fa_off  = t[PAGE_LOG2-1:0];
		fa_kind = page_kind_q[fa_page[PW-1:0]];
	end

	// --- scan conditions ---
	logic [7:0] ps_limit;
	logic       ps_end;
	logic       ps_free;
	logic       sr_pg_end;
	logic       sr_split;
	logic       sr_last_lvl;
	logic       row_last;
	logic       cur_top;
	logic       bud_set;
	logic       rel;
	logic [PAGE_LOG2-1:0] hit_off;

	always_comb begin
		logic [31:0] t;
		ps_limit    = (32'(pages_allowed_q) < 32'(NUM_PAGES)) ? 8'(pages_allowed_q)
		                                                      : 8'(NUM_PAGES);
		ps_end      = 8'(pg_q) >= ps_limit;
		ps_free     = page_kind_q[pg_q[PW-1:0]] == KIND_UNUSED;
		sr_pg_end   = 32'(pg_q) >= 32'(NUM_PAGES);
		sr_split    = page_kind_q[pg_q[PW-1:0]] == KIND_SPLIT;
		sr_last_lvl = (32'(cur_q) + 32'(1)) == 32'(SIZE_LEVELS);
		row_last    = row_q == last_row(cur_q);
		cur_top     = cur_q == LW'(SIZE_LEVELS);
		bud_set     = row_val[bit_q];
		// lowest hit in this row becomes the block offset
		t = (32'({row_q, hit_bit}) ^ (32'(1) << (SIZE_LEVELS - int'(cur_q))))
		    << (MIN_BLOCK_LOG2 + int'(cur_q));
		hit_off = t[PAGE_LOG2-1:0];
		// page goes back to unused, or is opened fresh for splitting
		rel = ((state_q == S_PSCAN) && !ps_end && ps_free && !whole_q) ||
		      ((state_q == S_BUD) && cur_top);
	end

	// rows never written since the page was opened read as zero
	assign ram_addr = {pg_q[PW-1:0], row_q};
	assign row_val  = row_valid_q[ram_addr] ? ram_rdata : '0;

	bba_ram #(
		.WIDTH (W),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	bba_row_search #(
		.SIZE_LEVELS (SIZE_LEVELS),
		.ROW_LOG2    (ROW_LOG2)
	) u_search (
		.row_data (row_val),
		.row_idx  (row_q),
		.level    (cur_q),
		.hit      (hit),
		.hit_bit  (hit_bit)
	);

	// --- next state ---
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (dec_bad) begin
					state_d = S_FIN;
				end else if (req_q.action == ACT_ALLOC) begin
					state_d = dec_whole ? S_PSCAN : S_SRD;
				end else if (!fa_page_ok || dec_whole || fa_kind != KIND_SPLIT) begin
					state_d = S_FIN;
				end else begin
					state_d = S_BUD;
				end
			end
			S_PSCAN: begin
				if (ps_end) state_d = S_FIN;
				else if (ps_free) state_d = whole_q ? S_FIN : S_SPL;
			end
			S_SRD: begin
				if (sr_pg_end) begin
					if (sr_last_lvl) state_d = S_PSCAN;
				end else if (sr_split) begin
					state_d = S_SCHK;
				end
			end
			S_SCHK: begin
				state_d = hit ? S_SPL : S_SRD;
			end
			S_SPL: begin
				state_d = (cur_q == lvl_q) ? S_FIN : S_MRD;
			end
			S_MRD: state_d = S_MWR;
			S_MWR: begin
				state_d = (req_q.action == ACT_FREE) ? S_FIN : S_SPL;
			end
			S_BUD: begin
				state_d = cur_top ? S_FIN : S_BRD;
			end
			S_BRD: state_d = S_BCHK;
			S_BCHK: begin
				state_d = bud_set ? S_BUD : S_MRD;
			end
			S_FIN: begin
				if (!rsp_valid_q || !rsp_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// --- outputs of the sequencer ---
	always_comb begin
		req_stall = (state_q != S_IDLE);
		ram_we    = 1'b0;
		ram_wdata = row_val;
		unique case (state_q)
			S_SCHK: begin
				ram_we    = hit;
				ram_wdata = row_val & ~(W'(1) << hit_bit);
			end
			S_MWR: begin
				ram_we    = 1'b1;
				ram_wdata = row_val | (W'(1) << bit_q);
			end
			S_BCHK: begin
				ram_we    = bud_set;
				ram_wdata = row_val & ~(W'(1) << bit_q);
			end
			default: begin
				ram_we    = 1'b0;
				ram_wdata = row_val;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_allowed_q <= PAGES_ALLOWED_RST;
		end else if (cfg_we) begin
			pages_allowed_q <= cfg_wdata;
		end
	end

	// page table and row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PAGES_P2; p++) page_kind_q[p] <= KIND_UNUSED;
			row_valid_q <= '0;
		end else begin
			if (rel) begin
				for (int r = 0; r < ROWS; r++) begin
					row_valid_q[{pg_q[PW-1:0], RB'(r)}] <= 1'b0;
				end
			end
			if (ram_we) row_valid_q[ram_addr] <= 1'b1;
			if (state_q == S_DECODE && !dec_bad && req_q.action == ACT_FREE &&
			    fa_page_ok && dec_whole && fa_kind == KIND_WHOLE) begin
				page_kind_q[fa_page[PW-1:0]] <= KIND_UNUSED;
			end
			if (state_q == S_PSCAN && !ps_end && ps_free) begin
				page_kind_q[pg_q[PW-1:0]] <= whole_q ? KIND_WHOLE : KIND_SPLIT;
			end
			if (state_q == S_BUD && cur_top) begin
				page_kind_q[pg_q[PW-1:0]] <= KIND_UNUSED;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FIN && (!rsp_valid_q || !rsp_stall)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] ga;
		ga = (32'(pg_q) << PAGE_LOG2) | 32'(off_q);
		if (state_q == S_FIN && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.granted_address <= grant_q ? ga[15:0] : 16'd0;
			rsp_q.status          <= status_q;
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		logic [NB-1:0] nd;
		nd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) req_q <= req;
			end
			S_DECODE: begin
				status_q <= dec_bad ? ST_RANGE : ST_OK;
				grant_q  <= 1'b0;
				cur_q    <= dec_lvl;
				lvl_q    <= dec_lvl;
				whole_q  <= dec_whole;
				row_q    <= first_row(dec_lvl);
				if (req_q.action == ACT_ALLOC) begin
					pg_q  <= '0;
					off_q <= '0;
				end else begin
					pg_q  <= PCW'(fa_page);
					off_q <= fa_off;
				end
			end
			S_PSCAN: begin
				if (ps_end) begin
					status_q <= ST_OOM;
				end else if (ps_free) begin
					grant_q <= 1'b1;
					off_q   <= '0;
					cur_q   <= LW'(SIZE_LEVELS);
				end else begin
					pg_q <= pg_q + PCW'(1);
				end
			end
			S_SRD: begin
				if (sr_pg_end) begin
					pg_q <= '0;
					if (!sr_last_lvl) begin
						cur_q <= cur_q + LW'(1);
						row_q <= first_row(cur_q + LW'(1));
					end
				end else if (!sr_split) begin
					pg_q  <= pg_q + PCW'(1);
					row_q <= first_row(cur_q);
				end
			end
			S_SCHK: begin
				if (hit) begin
					off_q   <= hit_off;
					grant_q <= 1'b1;
				end else if (row_last) begin
					pg_q  <= pg_q + PCW'(1);
					row_q <= first_row(cur_q);
				end else begin
					row_q <= row_q + RB'(1);
				end
			end
			S_SPL: begin
				// mark the right half of the next lower level free
				if (cur_q != lvl_q) begin
					nd    = node_of(cur_q - LW'(1), off_q | blk(cur_q - LW'(1)));
					cur_q <= cur_q - LW'(1);
					row_q <= nd[NB-1:ROW_LOG2];
					bit_q <= nd[ROW_LOG2-1:0];
				end
			end
			S_BUD: begin
				if (!cur_top) begin
					nd    = node_of(cur_q, off_q ^ blk(cur_q));
					row_q <= nd[NB-1:ROW_LOG2];
					bit_q <= nd[ROW_LOG2-1:0];
				end
			end
			S_BCHK: begin
				if (bud_set) begin
					off_q <= off_q & ~blk(cur_q);
					cur_q <= cur_q + LW'(1);
				end else begin
					nd    = node_of(cur_q, off_q);
					row_q <= nd[NB-1:ROW_LOG2];
					bit_q <= nd[ROW_LOG2-1:0];
				end
			end
			default: begin
				nd = '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_OK) |-> (rsp.granted_address == 16'd0))
		else $error("failed response carries an address");

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second beat taken while busy");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_DECODE) |-> (32'(cur_q) <= 32'(SIZE_LEVELS)))
		else $error("level walk out of range");

	a_write_page: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (32'(pg_q) < 32'(NUM_PAGES)))
		else $error("bitmap write outside the pool");
`endif

endmodule
`default_nettype wire
